// File: design/pdm_pkg.sv
package pdm_pkg;

  // fixed field widths
  localparam int GainW     = 16;
  localparam int OutLimW   = 15;
  localparam int IntLimW   = 23;
  localparam int IntegW    = 24;
  localparam int DriveW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 23;

  // parameter defaults
  localparam int SampleWidthDef  = 16;
  localparam int GainFracBitsDef = 8;

  // register reset values
  localparam logic [OutLimW-1:0] OutLimRst = {OutLimW{1'b1}};
  localparam logic [IntLimW-1:0] IntLimRst = {IntLimW{1'b1}};

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKp     = 3'd0,
    CfgKi     = 3'd1,
    CfgKd     = 3'd2,
    CfgOutLim = 3'd3,
    CfgIntLim = 3'd4
  } cfg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [OutLimW-1:0]      out_lim;
    logic [IntLimW-1:0]      int_lim;
  } cfg_t;

endpackage

// File: design/pdm_cfg_regs.sv
module pdm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pdm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pdm_pkg::CfgDataW-1:0]  cfg_data_i,
  output pdm_pkg::cfg_t                 cfg_o
);

  pdm_pkg::cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pdm_pkg::CfgKp:     cfg_d.kp      = cfg_data_i[pdm_pkg::GainW-1:0];
        pdm_pkg::CfgKi:     cfg_d.ki      = cfg_data_i[pdm_pkg::GainW-1:0];
        pdm_pkg::CfgKd:     cfg_d.kd      = cfg_data_i[pdm_pkg::GainW-1:0];
        pdm_pkg::CfgOutLim: cfg_d.out_lim = cfg_data_i[pdm_pkg::OutLimW-1:0];
        pdm_pkg::CfgIntLim: cfg_d.int_lim = cfg_data_i[pdm_pkg::IntLimW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp      <= '0;
      cfg_q.ki      <= '0;
      cfg_q.kd      <= '0;
      cfg_q.out_lim <= pdm_pkg::OutLimRst;
      cfg_q.int_lim <= pdm_pkg::IntLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/pdm_datapath.sv
module pdm_datapath #(
  parameter int SampleWidth  = pdm_pkg::SampleWidthDef,
  parameter int GainFracBits = pdm_pkg::GainFracBitsDef
) (
  input  pdm_pkg::cfg_t                        cfg_i,
  input  logic                                 clear_i,
  input  logic signed [SampleWidth-1:0]        target_i,
  input  logic signed [SampleWidth-1:0]        actual_i,
  input  logic signed [pdm_pkg::IntegW-1:0]    integ_i,
  input  logic signed [SampleWidth-1:0]        prev_i,
  output logic signed [pdm_pkg::IntegW-1:0]    integ_o,
  output logic signed [SampleWidth-1:0]        prev_o,
  output logic signed [pdm_pkg::DriveW-1:0]    drive_o,
  output logic                                 saturated_o
);

  // difference width, integral sum width, product widths, raw sum width
  localparam int EW  = SampleWidth + 1;
  localparam int ISW = ((pdm_pkg::IntegW > EW) ? pdm_pkg::IntegW : EW) + 1;
  localparam int PEW = pdm_pkg::GainW + EW;
  localparam int PIW = pdm_pkg::GainW + pdm_pkg::IntegW;
  localparam int RW  = ((PIW > PEW) ? PIW : PEW) + 2;

  logic signed [EW-1:0]  err, dmeas;
  logic signed [ISW-1:0] isum, ilim;
  logic signed [pdm_pkg::IntegW-1:0] integ_new;
  logic signed [PEW-1:0] p_kp, p_kd;
  logic signed [PIW-1:0] p_ki;
  logic signed [RW-1:0]  raw, shifted, olim;

  // error and derivative on measurement
  assign err   = EW'(target_i) - EW'(actual_i);
  assign dmeas = EW'(prev_i) - EW'(actual_i);

  // integral accumulate and clamp
  assign isum = ISW'(integ_i) + ISW'(err);
  assign ilim = ISW'($signed({1'b0, cfg_i.int_lim}));

  always_comb begin
    if (isum > ilim) begin
      integ_new = pdm_pkg::IntegW'(ilim);
    end else if (isum < -ilim) begin
      integ_new = pdm_pkg::IntegW'(-ilim);
    end else begin
      integ_new = pdm_pkg::IntegW'(isum);
    end
  end

  // gain products, exact
  assign p_kp = cfg_i.kp * err;
  assign p_ki = cfg_i.ki * integ_new;
  assign p_kd = cfg_i.kd * dmeas;

  // wide sum, floor shift
  assign raw     = RW'(p_kp) + RW'(p_ki) + RW'(p_kd);
  assign shifted = raw >>> GainFracBits;
  assign olim    = RW'($signed({1'b0, cfg_i.out_lim}));

  // output clamp and history update
  always_comb begin
    if (clear_i) begin
      integ_o     = '0;
      prev_o      = '0;
      drive_o     = '0;
      saturated_o = 1'b0;
    end else begin
      integ_o = integ_new;
      prev_o  = actual_i;
      if (shifted > olim) begin
        drive_o     = pdm_pkg::DriveW'(olim);
        saturated_o = 1'b1;
      end else if (shifted < -olim) begin
        drive_o     = pdm_pkg::DriveW'(-olim);
        saturated_o = 1'b1;
      end else begin
        drive_o     = pdm_pkg::DriveW'(shifted);
        saturated_o = 1'b0;
      end
    end
  end

endmodule

// File: design/pid_derivative_on_measurement.sv
// pid controller with derivative on measurement, fixed point
// path: input register then result register; out_valid_o rises when the item in the input register
// moves into the result register, which waits while out_stall_i holds a pending result
// throughput: one transaction per cycle unless out_stall_i holds a result; integral and previous actual
// update in the same cycle as the result is formed, so back-to-back items see each other's history
// reset: asynchronous active low; clears gains, sets both limits to full scale, zeroes history
module pid_derivative_on_measurement #(
  parameter int SampleWidth  = pdm_pkg::SampleWidthDef,
  parameter int GainFracBits = pdm_pkg::GainFracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [SampleWidth-1:0]        target_i,
  input  logic signed [SampleWidth-1:0]        actual_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pdm_pkg::DriveW-1:0]    drive_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pdm_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [pdm_pkg::CfgDataW-1:0]         cfg_data_i
);

  pdm_pkg::cfg_t cfg;

  logic                                in_vld_q;
  logic                                act_q;
  logic signed [SampleWidth-1:0]       tgt_q, meas_q;
  logic signed [pdm_pkg::IntegW-1:0]   integ_q, integ_d;
  logic signed [SampleWidth-1:0]       prev_q, prev_d;
  logic                                out_vld_q;
  logic signed [pdm_pkg::DriveW-1:0]   drive_q, drive_d;
  logic                                sat_q, sat_d;
  logic                                res_free, s1_fire, in_take;

  pdm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pdm_datapath #(
    .SampleWidth  (SampleWidth),
    .GainFracBits (GainFracBits)
  ) u_dp (
    .cfg_i       (cfg),
    .clear_i     (act_q),
    .target_i    (tgt_q),
    .actual_i    (meas_q),
    .integ_i     (integ_q),
    .prev_i      (prev_q),
    .integ_o     (integ_d),
    .prev_o      (prev_d),
    .drive_o     (drive_d),
    .saturated_o (sat_d)
  );

  // handshake between the two register stages
  assign res_free   = !out_vld_q || !out_stall_i;
  assign s1_fire    = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // control and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      integ_q   <= '0;
      prev_q    <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (s1_fire) begin
        in_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_q <= 1'b1;
        integ_q   <= integ_d;
        prev_q    <= prev_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q  <= action_i;
      tgt_q  <= target_i;
      meas_q <= actual_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SampleW    = pdm_pkg::SampleWidthDef;
  localparam int FracBits   = pdm_pkg::GainFracBitsDef;
  localparam int QuietLimit = 2000;

  typedef struct {
    logic signed [pdm_pkg::DriveW-1:0] drive;
    logic                              saturated;
  } drive_result_t;

  // predicts the controller output and matches it against the block
  class drive_scoreboard;
    longint        kp, ki, kd, out_lim, int_lim;
    longint        integral, prev_actual;
    drive_result_t expected_q[$];
    int            mismatch_count;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      out_lim = longint'(pdm_pkg::OutLimRst);
      int_lim = longint'(pdm_pkg::IntLimRst);
      integral = 0;
      prev_actual = 0;
      mismatch_count = 0;
    endfunction

    // bits above each register's width are dropped
    function void write_register(pdm_pkg::cfg_idx_e idx, logic [pdm_pkg::CfgDataW-1:0] data);
      case (idx)
        pdm_pkg::CfgKp: kp = longint'($signed(data[pdm_pkg::GainW-1:0]));
        pdm_pkg::CfgKi: ki = longint'($signed(data[pdm_pkg::GainW-1:0]));
        pdm_pkg::CfgKd: kd = longint'($signed(data[pdm_pkg::GainW-1:0]));
        pdm_pkg::CfgOutLim: out_lim = longint'(data[pdm_pkg::OutLimW-1:0]);
        pdm_pkg::CfgIntLim: int_lim = longint'(data[pdm_pkg::IntLimW-1:0]);
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    // one accepted sample in, one expected output queued
    function void note_sample(logic action, logic signed [SampleW-1:0] target,
                              logic signed [SampleW-1:0] actual);
      drive_result_t res;
      longint        err, raw;
      if (action) begin
        integral = 0;
        prev_actual = 0;
        res.drive = '0;
        res.saturated = 1'b0;
      end else begin
        err = longint'(target) - longint'(actual);
        integral = integral + err;
        if (integral > int_lim) integral = int_lim;
        else if (integral < -int_lim) integral = -int_lim;
        raw = kp * err + ki * integral + kd * (prev_actual - longint'(actual));
        // arithmetic shift floors towards minus infinity
        raw = raw >>> FracBits;
        prev_actual = longint'(actual);
        res.saturated = 1'b0;
        if (raw > out_lim) begin
          raw = out_lim;
          res.saturated = 1'b1;
        end else if (raw < -out_lim) begin
          raw = -out_lim;
          res.saturated = 1'b1;
        end
        res.drive = raw[pdm_pkg::DriveW-1:0];
      end
      expected_q.push_back(res);
    endfunction

    task check_drive(logic signed [pdm_pkg::DriveW-1:0] drive, logic saturated);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("drive %0d with nothing expected", drive));
        return;
      end
      want = expected_q.pop_front();
      if (drive !== want.drive)
        report_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
      if (saturated !== want.saturated)
        report_mismatch($sformatf("saturated %0b, expected %0b", saturated, want.saturated));
    endtask
  endclass

  logic                                clk;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic                                action_i;
  logic signed [SampleW-1:0]           target_i;
  logic signed [SampleW-1:0]           actual_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [pdm_pkg::DriveW-1:0]   drive_o;
  logic                                saturated_o;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic [pdm_pkg::CfgIdxW-1:0]         cfg_index_i;
  logic [pdm_pkg::CfgDataW-1:0]        cfg_data_i;

  drive_scoreboard sb;
  int              tx_idle_pct;
  int              rx_idle_pct;
  logic            hold_off;
  int              setpoint;
  int              last_actual;

  pid_derivative_on_measurement DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .target_i    (target_i),
    .actual_i    (actual_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure, with an optional long hold-off
  always @(negedge clk) begin
    out_stall_i = hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  // watch every channel for a transaction at the clock edge
  always @(posedge clk) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_register(pdm_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_sample(action_i, target_i, actual_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_drive(drive_o, saturated_o);
  end

  // give up when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one sample, with random gaps ahead of it
  task automatic send_sample(logic action, logic signed [SampleW-1:0] target,
                             logic signed [SampleW-1:0] actual);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i = 1'b1;
    action_i = action;
    target_i = target;
    actual_i = actual;
    do @(posedge clk); while (in_stall_o);
  endtask

  function automatic int extreme_value();
    case ($urandom_range(4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // mostly a plant tracking its setpoint, some noise and clears
  task automatic send_random_sample();
    int   pick, t, a;
    logic act;
    act = ($urandom_range(99) < 6);
    if ($urandom_range(99) < 3) setpoint = int'($urandom_range(65535)) - 32768;
    pick = $urandom_range(99);
    if (pick < 55) begin
      t = setpoint;
      a = last_actual + (setpoint - last_actual) / 8 + int'($urandom_range(128)) - 64;
    end else if (pick < 85) begin
      t = int'($urandom_range(65535)) - 32768;
      a = int'($urandom_range(65535)) - 32768;
    end else begin
      t = extreme_value();
      a = extreme_value();
    end
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    last_actual = a;
    send_sample(act, t[SampleW-1:0], a[SampleW-1:0]);
  endtask

  // let every outstanding result come back, then settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // spare upper data bits carry noise that the block must ignore
  task automatic write_register(pdm_pkg::cfg_idx_e idx, int value);
    logic [pdm_pkg::CfgDataW-1:0] data;
    data = pdm_pkg::CfgDataW'($urandom);
    case (idx)
      pdm_pkg::CfgKp, pdm_pkg::CfgKi, pdm_pkg::CfgKd:
        data[pdm_pkg::GainW-1:0] = value[pdm_pkg::GainW-1:0];
      pdm_pkg::CfgOutLim: data[pdm_pkg::OutLimW-1:0] = value[pdm_pkg::OutLimW-1:0];
      default: data = value[pdm_pkg::CfgDataW-1:0];
    endcase
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk); while (!cfg_ready_o);
  endtask

  task automatic set_config(int gain_p, int gain_i, int gain_d, int out_lim, int int_lim);
    wait_drained();
    write_register(pdm_pkg::CfgKp, gain_p);
    write_register(pdm_pkg::CfgKi, gain_i);
    write_register(pdm_pkg::CfgKd, gain_d);
    write_register(pdm_pkg::CfgOutLim, out_lim);
    write_register(pdm_pkg::CfgIntLim, int_lim);
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  function automatic int pick_gain(int flavour);
    case (flavour)
      0: begin
        case ($urandom_range(2))
          0: return -32768;
          1: return 0;
          default: return 32767;
        endcase
      end
      1: return int'($urandom_range(1023)) - 512;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic random_config(int flavour);
    int ol, il;
    case (flavour)
      0: begin
        ol = $urandom_range(1) ? 32767 : 0;
        il = $urandom_range(1) ? 8388607 : 0;
      end
      1: begin
        ol = $urandom_range(4000);
        il = $urandom_range(200000);
      end
      default: begin
        ol = $urandom_range(32767);
        il = $urandom_range(8388607);
      end
    endcase
    set_config(pick_gain(flavour), pick_gain(flavour), pick_gain(flavour), ol, il);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    target_i = '0;
    actual_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pdm_pkg::CfgKp;
    cfg_data_i = '0;
    hold_off = 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 63;
    setpoint = 0;
    last_actual = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // output exactly at and just past its limit, then a clear with live fields
    set_config(256, 0, 0, 1000, 8388607);
    send_sample(1'b0, 1000, 0);
    send_sample(1'b0, 1001, 0);
    send_sample(1'b0, -1000, 0);
    send_sample(1'b0, 0, 1001);
    send_sample(1'b1, 32767, -32768);

    // fractional results floor towards minus infinity
    set_config(1, 0, 0, 32767, 8388607);
    send_sample(1'b0, -1, 0);
    send_sample(1'b0, 255, 0);
    send_sample(1'b0, -256, 0);
    send_sample(1'b0, -257, 0);
    send_sample(1'b0, 256, 0);

    // integral landing on its limit, then pushed past either side
    set_config(0, 256, 0, 32767, 500);
    send_sample(1'b1, 0, 0);
    send_sample(1'b0, 300, 0);
    send_sample(1'b0, 200, 0);
    send_sample(1'b0, 1, 0);
    send_sample(1'b0, -1200, 0);

    // both limits zero with full-scale gains
    set_config(32767, -32768, 32767, 0, 0);
    send_sample(1'b0, 0, 0);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, -32768, 32767);

    // opposite extreme gains, full limits, widest error swings
    set_config(-32768, 32767, -32768, 32767, 8388607);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, 32767, -32768);
    send_sample(1'b0, -32768, 32767);
    send_sample(1'b1, -1, -1);

    // random phases under three idling patterns
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 63;
        end
        1: begin
          tx_idle_pct = 63;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        random_config((k + 1) % 3);
        // receiver holds off so the block backs up into its input
        if (regime == 2 && k == 1) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (60) @(posedge clk);
              hold_off = 1'b0;
            end
            repeat (80) send_random_sample();
          join
        end
        repeat (140) send_random_sample();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch("results still outstanding at the end");
    if (sb.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
